### src/cdce_pkg.sv
// shared constants, types and helpers of the column drop cascade eliminator
package cdce_pkg;

	localparam int NUM_COLS  = 64;
	localparam int NUM_ROWS  = 64;
	localparam int COL_W     = $clog2(NUM_COLS);
	localparam int ROW_W     = $clog2(NUM_ROWS);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int NUM_CELLS = 1 << ADDR_W;
	localparam int CNT_W     = ADDR_W + 1;
	localparam int H_W       = $clog2(NUM_ROWS + 1);
	localparam int SC_W      = $clog2(NUM_COLS + 1);
	localparam int EP_W      = 8;

	localparam int COLUMN_W  = 6;
	localparam int SP_W      = 8;
	localparam int SLOPE_W   = 8;
	localparam int MASS_W    = 13;
	localparam int CLU_W     = 12;
	localparam int GEN_W     = 12;
	localparam int EXT_W     = 7;

	typedef logic [ADDR_W-1:0] cell_addr_t;

	typedef enum logic [4:0] {
		OP_CLEAR,
		OP_IDLE,
		OP_HRD0,
		OP_HRD1,
		OP_HCHK,
		OP_DECIDE,
		OP_LAND,
		OP_GEN,
		OP_VCLR,
		OP_SEED,
		OP_SRD,
		OP_SCHK,
		OP_POP,
		OP_PRD,
		OP_NB,
		OP_NCHK,
		OP_COMP,
		OP_RM,
		OP_RMW,
		OP_SETTLE,
		OP_SCOL,
		OP_SHRD,
		OP_SRC,
		OP_SRCW,
		OP_SZERO,
		OP_SHWR,
		OP_DONE
	} cdce_op_t;

	typedef struct packed {
		cdce_op_t op;
		logic     load;
		logic     emit;
	} cdce_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic full;
		logic sp_zero;
		logic ep_wrap;
		logic seed_end;
		logic seed_skip;
		logic q_empty;
		logic nb_ok;
		logic nb_last;
		logic multi;
		logic rm_end;
		logic col_end;
		logic col_dirty;
		logic moved_none;
		logic src_end;
		logic src_nz;
		logic src_move;
	} cdce_sts_t;

	typedef struct packed {
		logic               ceiling_hit;
		logic [SLOPE_W-1:0] local_slope;
		logic [MASS_W-1:0]  cascade_mass;
		logic [CLU_W-1:0]   cluster_count;
		logic [GEN_W-1:0]   generation_count;
		logic [EXT_W-1:0]   column_extent;
	} cdce_res_t;

	function automatic cell_addr_t cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		return {r, c};
	endfunction

endpackage

### src/cdce_ctrl.sv
// sequencer for landing, flood fill, removal and column compaction
module cdce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_free,
	input  cdce_pkg::cdce_sts_t sts,
	output cdce_pkg::cdce_cmd_t cmd
);
	import cdce_pkg::*;

	typedef enum logic [26:0] {
		ST_CLEAR  = 27'd1 << 0,
		ST_IDLE   = 27'd1 << 1,
		ST_HRD0   = 27'd1 << 2,
		ST_HRD1   = 27'd1 << 3,
		ST_HCHK   = 27'd1 << 4,
		ST_DECIDE = 27'd1 << 5,
		ST_LAND   = 27'd1 << 6,
		ST_GEN    = 27'd1 << 7,
		ST_VCLR   = 27'd1 << 8,
		ST_SEED   = 27'd1 << 9,
		ST_SRD    = 27'd1 << 10,
		ST_SCHK   = 27'd1 << 11,
		ST_POP    = 27'd1 << 12,
		ST_PRD    = 27'd1 << 13,
		ST_NB     = 27'd1 << 14,
		ST_NCHK   = 27'd1 << 15,
		ST_COMP   = 27'd1 << 16,
		ST_RM     = 27'd1 << 17,
		ST_RMW    = 27'd1 << 18,
		ST_SETTLE = 27'd1 << 19,
		ST_SCOL   = 27'd1 << 20,
		ST_SHRD   = 27'd1 << 21,
		ST_SRC    = 27'd1 << 22,
		ST_SRCW   = 27'd1 << 23,
		ST_SZERO  = 27'd1 << 24,
		ST_SHWR   = 27'd1 << 25,
		ST_DONE   = 27'd1 << 26
	} cdce_state_t;

	cdce_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd.op   = OP_IDLE;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.op   = OP_IDLE;
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_HRD0;
				end
			end
			ST_HRD0: begin
				cmd.op  = OP_HRD0;
				state_d = ST_HRD1;
			end
			ST_HRD1: begin
				cmd.op  = OP_HRD1;
				state_d = ST_HCHK;
			end
			ST_HCHK: begin
				cmd.op  = OP_HCHK;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.op  = OP_DECIDE;
				state_d = (sts.full || sts.sp_zero) ? ST_DONE : ST_LAND;
			end
			ST_LAND: begin
				cmd.op  = OP_LAND;
				state_d = ST_GEN;
			end
			ST_GEN: begin
				cmd.op  = OP_GEN;
				state_d = sts.ep_wrap ? ST_VCLR : ST_SEED;
			end
			ST_VCLR: begin
				cmd.op = OP_VCLR;
				if (sts.clr_last) state_d = ST_SEED;
			end
			ST_SEED: begin
				cmd.op  = OP_SEED;
				state_d = sts.seed_end ? ST_SETTLE : ST_SRD;
			end
			ST_SRD: begin
				cmd.op  = OP_SRD;
				state_d = ST_SCHK;
			end
			ST_SCHK: begin
				cmd.op  = OP_SCHK;
				state_d = sts.seed_skip ? ST_SEED : ST_POP;
			end
			ST_POP: begin
				cmd.op  = OP_POP;
				state_d = sts.q_empty ? ST_COMP : ST_PRD;
			end
			ST_PRD: begin
				cmd.op  = OP_PRD;
				state_d = ST_NB;
			end
			ST_NB: begin
				cmd.op = OP_NB;
				if (sts.nb_ok) state_d = ST_NCHK;
				else state_d = sts.nb_last ? ST_POP : ST_NB;
			end
			ST_NCHK: begin
				cmd.op  = OP_NCHK;
				state_d = sts.nb_last ? ST_POP : ST_NB;
			end
			ST_COMP: begin
				cmd.op  = OP_COMP;
				state_d = sts.multi ? ST_RM : ST_SEED;
			end
			ST_RM: begin
				cmd.op  = OP_RM;
				state_d = sts.rm_end ? ST_SEED : ST_RMW;
			end
			ST_RMW: begin
				cmd.op  = OP_RMW;
				state_d = ST_RM;
			end
			ST_SETTLE: begin
				cmd.op  = OP_SETTLE;
				state_d = ST_SCOL;
			end
			ST_SCOL: begin
				cmd.op = OP_SCOL;
				if (sts.col_end) state_d = sts.moved_none ? ST_DONE : ST_GEN;
				else if (sts.col_dirty) state_d = ST_SHRD;
			end
			ST_SHRD: begin
				cmd.op  = OP_SHRD;
				state_d = ST_SRC;
			end
			ST_SRC: begin
				cmd.op  = OP_SRC;
				state_d = sts.src_end ? ST_SHWR : ST_SRCW;
			end
			ST_SRCW: begin
				cmd.op  = OP_SRCW;
				state_d = (sts.src_nz && sts.src_move) ? ST_SZERO : ST_SRC;
			end
			ST_SZERO: begin
				cmd.op  = OP_SZERO;
				state_d = ST_SRC;
			end
			ST_SHWR: begin
				cmd.op  = OP_SHWR;
				state_d = ST_SCOL;
			end
			ST_DONE: begin
				cmd.op = OP_DONE;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

### src/cdce_dp.sv
// lattice memories, search queue, moved list, counters and totals
module cdce_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [cdce_pkg::COLUMN_W-1:0]     column,
	input  logic [cdce_pkg::SP_W-1:0]         species,
	input  cdce_pkg::cdce_cmd_t               cmd,
	output cdce_pkg::cdce_sts_t               sts,
	output cdce_pkg::cdce_res_t               res
);
	import cdce_pkg::*;

	// memories
	logic [SP_W-1:0]   cells_mem [NUM_CELLS];
	logic [EP_W-1:0]   vis_mem   [NUM_CELLS];
	cell_addr_t        queue_mem [NUM_CELLS];
	cell_addr_t        moved_mem [NUM_CELLS];
	logic [H_W-1:0]    hgt_mem   [NUM_COLS];

	logic [SP_W-1:0]   c_rdata_q, c_wdata;
	logic [EP_W-1:0]   v_rdata_q;
	cell_addr_t        q_rdata_q, m_rdata_q, q_wdata, m_wdata;
	logic [H_W-1:0]    h_rdata_q, h_wdata;
	cell_addr_t        c_raddr, c_waddr, v_waddr, q_raddr, q_waddr, m_raddr, m_waddr;
	logic [COL_W-1:0]  h_raddr, h_waddr;
	logic              c_we, v_we, q_we, m_we, h_we;
	logic [EP_W-1:0]   v_wdata;

	// registers
	logic [COL_W-1:0]   col_q;
	logic [SP_W-1:0]    sp_q, spc_q;
	logic [H_W-1:0]     h_col_q, h_nxt_q, hc_q, src_q, put_q;
	logic               ceil_q, gen_any_q;
	logic [SLOPE_W-1:0] slope_q;
	logic [EP_W-1:0]    epoch_q;
	cell_addr_t         clr_q, cur_q, nb_q;
	logic [CNT_W-1:0]   moved_cnt_q, seed_q, head_q, tail_q, k_q;
	logic [1:0]         nbsel_q;
	logic [NUM_COLS-1:0] dirty_q, touched_q;
	logic [MASS_W-1:0]  mass_q;
	logic [CLU_W-1:0]   clu_q;
	logic [GEN_W-1:0]   gen_q;
	logic [EXT_W-1:0]   ext_q;
	logic [SC_W-1:0]    scol_q;

	logic [ROW_W-1:0]   cur_r;
	logic [COL_W-1:0]   cur_c, scol_c, rm_c;
	cell_addr_t         nb, pos, src_addr, dst_addr;
	logic               nb_ok, hit;
	logic [MASS_W:0]    mass_sum;

	assign cur_r    = cur_q[ADDR_W-1 -: ROW_W];
	assign cur_c    = cur_q[COL_W-1:0];
	assign scol_c   = scol_q[COL_W-1:0];
	assign rm_c     = q_rdata_q[COL_W-1:0];
	assign pos      = cell_addr(ROW_W'(NUM_ROWS - 1) - ROW_W'(h_col_q), col_q);
	assign src_addr = cell_addr(ROW_W'(NUM_ROWS - 1) - ROW_W'(src_q), scol_c);
	assign dst_addr = cell_addr(ROW_W'(NUM_ROWS - 1) - ROW_W'(put_q), scol_c);
	assign hit      = (c_rdata_q == spc_q) && (v_rdata_q != epoch_q);
	assign mass_sum = (MASS_W+1)'(mass_q) + (MASS_W+1)'(tail_q);

	// neighbour of the current cell, columns wrap
	always_comb begin
		nb    = cur_q;
		nb_ok = 1'b1;
		case (nbsel_q)
			2'd0: begin
				nb_ok = (cur_r != '0);
				nb    = cell_addr(cur_r - 1'b1, cur_c);
			end
			2'd1: begin
				nb_ok = (cur_r != ROW_W'(NUM_ROWS - 1));
				nb    = cell_addr(cur_r + 1'b1, cur_c);
			end
			2'd2: nb = cell_addr(cur_r, (cur_c == '0) ? COL_W'(NUM_COLS - 1) : cur_c - 1'b1);
			2'd3: nb = cell_addr(cur_r, (cur_c == COL_W'(NUM_COLS - 1)) ? '0 : cur_c + 1'b1);
			default: nb = cur_q;
		endcase
	end

	always_comb begin
		sts.clr_last   = &clr_q;
		sts.full       = (h_col_q >= H_W'(NUM_ROWS));
		sts.sp_zero    = (sp_q == '0);
		sts.ep_wrap    = &epoch_q;
		sts.seed_end   = (seed_q == moved_cnt_q);
		sts.seed_skip  = (c_rdata_q == '0) || (v_rdata_q == epoch_q);
		sts.q_empty    = (head_q == tail_q);
		sts.nb_ok      = nb_ok;
		sts.nb_last    = (nbsel_q == 2'd3);
		sts.multi      = (tail_q > CNT_W'(1));
		sts.rm_end     = (k_q == tail_q);
		sts.col_end    = (scol_q == SC_W'(NUM_COLS));
		sts.col_dirty  = dirty_q[scol_c];
		sts.moved_none = (moved_cnt_q == '0);
		sts.src_end    = (src_q == hc_q);
		sts.src_nz     = (c_rdata_q != '0);
		sts.src_move   = (src_q != put_q);
	end

	// memory port steering
	always_comb begin
		c_raddr = cur_q;  c_we = 1'b0; c_waddr = clr_q; c_wdata = '0;
		v_we    = 1'b0;   v_waddr = clr_q; v_wdata = '0;
		q_raddr = head_q[ADDR_W-1:0]; q_we = 1'b0; q_waddr = '0; q_wdata = cur_q;
		m_raddr = seed_q[ADDR_W-1:0]; m_we = 1'b0; m_waddr = '0; m_wdata = pos;
		h_raddr = col_q;  h_we = 1'b0; h_waddr = clr_q[COL_W-1:0]; h_wdata = '0;
		case (cmd.op)
			OP_CLEAR: begin
				c_we = 1'b1;
				v_we = 1'b1;
				h_we = 1'b1;
			end
			OP_VCLR: v_we = 1'b1;
			OP_HRD1: h_raddr = (col_q == COL_W'(NUM_COLS - 1)) ? '0 : col_q + 1'b1;
			OP_LAND: begin
				c_we    = 1'b1;
				c_waddr = pos;
				c_wdata = sp_q;
				h_we    = 1'b1;
				h_waddr = col_q;
				h_wdata = h_col_q + 1'b1;
				m_we    = 1'b1;
			end
			OP_SRD: c_raddr = m_rdata_q;
			OP_SCHK: begin
				if (!sts.seed_skip) begin
					v_we    = 1'b1;
					v_waddr = cur_q;
					v_wdata = epoch_q;
					q_we    = 1'b1;
				end
			end
			OP_NB: c_raddr = nb;
			OP_NCHK: begin
				if (hit) begin
					v_we    = 1'b1;
					v_waddr = nb_q;
					v_wdata = epoch_q;
					q_we    = 1'b1;
					q_waddr = tail_q[ADDR_W-1:0];
					q_wdata = nb_q;
				end
			end
			OP_RM: q_raddr = k_q[ADDR_W-1:0];
			OP_RMW: begin
				c_we    = 1'b1;
				c_waddr = q_rdata_q;
			end
			OP_SCOL: h_raddr = scol_c;
			OP_SRC: c_raddr = src_addr;
			OP_SRCW: begin
				if (sts.src_nz && sts.src_move) begin
					c_we    = 1'b1;
					c_waddr = dst_addr;
					c_wdata = c_rdata_q;
					m_we    = 1'b1;
					m_waddr = moved_cnt_q[ADDR_W-1:0];
					m_wdata = dst_addr;
				end
			end
			OP_SZERO: begin
				c_we    = 1'b1;
				c_waddr = src_addr;
			end
			OP_SHWR: begin
				h_we    = 1'b1;
				h_waddr = scol_c;
				h_wdata = put_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (c_we) cells_mem[c_waddr] <= c_wdata;
		c_rdata_q <= cells_mem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (v_we) vis_mem[v_waddr] <= v_wdata;
		v_rdata_q <= vis_mem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) queue_mem[q_waddr] <= q_wdata;
		q_rdata_q <= queue_mem[q_raddr];
	end

	always_ff @(posedge clk) begin
		if (m_we) moved_mem[m_waddr] <= m_wdata;
		m_rdata_q <= moved_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (h_we) hgt_mem[h_waddr] <= h_wdata;
		h_rdata_q <= hgt_mem[h_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= column[COL_W-1:0];
			sp_q  <= species;
		end
		case (cmd.op)
			OP_HRD1: h_col_q <= h_rdata_q;
			OP_HCHK: h_nxt_q <= h_rdata_q;
			OP_SRD:  cur_q   <= m_rdata_q;
			OP_SCHK: spc_q   <= c_rdata_q;
			OP_PRD:  cur_q   <= q_rdata_q;
			OP_NB:   nb_q    <= nb;
			OP_SHRD: hc_q    <= h_rdata_q;
			default: ;
		endcase
	end

	// control registers and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			epoch_q     <= '0;
			ceil_q      <= 1'b0;
			slope_q     <= '0;
			moved_cnt_q <= '0;
			seed_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			k_q         <= '0;
			nbsel_q     <= '0;
			dirty_q     <= '0;
			touched_q   <= '0;
			mass_q      <= '0;
			clu_q       <= '0;
			gen_q       <= '0;
			ext_q       <= '0;
			gen_any_q   <= 1'b0;
			scol_q      <= '0;
			src_q       <= '0;
			put_q       <= '0;
		end else begin
			case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + 1'b1;
				OP_VCLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) epoch_q <= EP_W'(1);
				end
				OP_DECIDE: begin
					ceil_q    <= sts.full;
					slope_q   <= sts.full ? '0 : SLOPE_W'(h_nxt_q) - SLOPE_W'(h_col_q);
					mass_q    <= '0;
					clu_q     <= '0;
					gen_q     <= '0;
					ext_q     <= '0;
					touched_q <= '0;
				end
				OP_LAND: moved_cnt_q <= CNT_W'(1);
				OP_GEN: begin
					epoch_q   <= epoch_q + 1'b1;
					dirty_q   <= '0;
					seed_q    <= '0;
					gen_any_q <= 1'b0;
				end
				OP_SCHK: begin
					if (sts.seed_skip) begin
						seed_q <= seed_q + 1'b1;
					end else begin
						head_q <= '0;
						tail_q <= CNT_W'(1);
					end
				end
				OP_POP: if (!sts.q_empty) head_q <= head_q + 1'b1;
				OP_PRD: nbsel_q <= '0;
				OP_NB: if (!nb_ok) nbsel_q <= nbsel_q + 1'b1;
				OP_NCHK: begin
					nbsel_q <= nbsel_q + 1'b1;
					if (hit) tail_q <= tail_q + 1'b1;
				end
				OP_COMP: begin
					k_q <= '0;
					if (!sts.multi) seed_q <= seed_q + 1'b1;
				end
				OP_RM: begin
					if (sts.rm_end) begin
						seed_q    <= seed_q + 1'b1;
						gen_any_q <= 1'b1;
						if (!(&clu_q)) clu_q <= clu_q + 1'b1;
						mass_q <= (mass_sum > (MASS_W+1)'({MASS_W{1'b1}})) ?
							{MASS_W{1'b1}} : mass_sum[MASS_W-1:0];
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				OP_RMW: begin
					dirty_q[rm_c] <= 1'b1;
					if (!touched_q[rm_c]) begin
						touched_q[rm_c] <= 1'b1;
						if (!(&ext_q)) ext_q <= ext_q + 1'b1;
					end
				end
				OP_SETTLE: begin
					if (gen_any_q && !(&gen_q)) gen_q <= gen_q + 1'b1;
					moved_cnt_q <= '0;
					scol_q      <= '0;
				end
				OP_SCOL: if (!sts.col_end && !sts.col_dirty) scol_q <= scol_q + 1'b1;
				OP_SHRD: begin
					src_q <= '0;
					put_q <= '0;
				end
				OP_SRCW: begin
					if (sts.src_nz) begin
						put_q <= put_q + 1'b1;
						if (sts.src_move) moved_cnt_q <= moved_cnt_q + 1'b1;
						else src_q <= src_q + 1'b1;
					end else begin
						src_q <= src_q + 1'b1;
					end
				end
				OP_SZERO: src_q <= src_q + 1'b1;
				OP_SHWR: scol_q <= scol_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign res.ceiling_hit      = ceil_q;
	assign res.local_slope      = slope_q;
	assign res.cascade_mass     = mass_q;
	assign res.cluster_count    = clu_q;
	assign res.generation_count = gen_q;
	assign res.column_extent    = ext_q;

endmodule

### src/column_drop_cascade_eliminator.sv
// top level of the column drop cascade eliminator: sequencer, datapath and result register
// One beat in drops a block of a species onto a column of a 64 x 64 lattice that wraps
// left to right and rests on a floor; one beat out reports whether the column was full,
// the slope to the right-hand neighbour before landing, and the totals of the cascade
// (cells removed, clusters removed, generations that removed cells, columns touched).
// After reset a clearing pass over all 4096 cells empties the lattice before the first beat
// is taken. Items are handled one at a time by a single sequencer working through
// memories with one read and one write port and registered reads, so the time per item
// follows the data: a full column or species zero skips the landing and the cascade; a drop
// runs, per generation, a flood fill from each seed, the removal of each group of two or
// more cells, a sweep over the columns and the compaction of each column that lost cells.
// Every 255th generation the visited tags are swept again over all 4096 cells. A finished
// result sits in the output register while the next beat is already accepted.
module column_drop_cascade_eliminator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cdce_pkg::COLUMN_W-1:0] column,
	input  logic [cdce_pkg::SP_W-1:0]     species,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ceiling_hit,
	output logic signed [cdce_pkg::SLOPE_W-1:0] local_slope,
	output logic [cdce_pkg::MASS_W-1:0]   cascade_mass,
	output logic [cdce_pkg::CLU_W-1:0]    cluster_count,
	output logic [cdce_pkg::GEN_W-1:0]    generation_count,
	output logic [cdce_pkg::EXT_W-1:0]    column_extent
);
	import cdce_pkg::*;

	cdce_cmd_t cmd;
	cdce_sts_t sts;
	cdce_res_t res;
	cdce_res_t res_q;
	logic      out_valid_q;
	logic      out_free;

	// output register may be reloaded in the cycle its beat leaves
	assign out_free = !out_valid_q || out_ready;

	cdce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	cdce_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.column  (column),
		.species (species),
		.cmd     (cmd),
		.sts     (sts),
		.res     (res)
	);

	// result beat holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign ceiling_hit      = res_q.ceiling_hit;
	assign local_slope      = $signed(res_q.local_slope);
	assign cascade_mass     = res_q.cascade_mass;
	assign cluster_count    = res_q.cluster_count;
	assign generation_count = res_q.generation_count;
	assign column_extent    = res_q.column_extent;

endmodule

### tb/column_drop_cascade_eliminator_test.sv
// testbench of the column drop cascade eliminator: lattice predictor, scoreboard and drivers
`timescale 1ns / 1ps

module column_drop_cascade_eliminator_test;
	import cdce_pkg::*;

	// own copy of the lattice, the column heights and the cascade bookkeeping;
	// every accepted drop is played through it to get the expected result beat
	class drop_scoreboard;
		byte unsigned lattice [NUM_CELLS];
		int           col_height [NUM_COLS];
		bit           seen [NUM_CELLS];
		int           fill_queue [NUM_CELLS];
		int           shifted [NUM_CELLS];
		int           n_shifted;
		int           deepest_gap [NUM_COLS];
		bit           col_lost [NUM_COLS];
		bit           col_hit [NUM_COLS];
		int           removed, clusters, generations, columns_hit;
		cdce_res_t    expected_beats [$];
		int           errors;
		int           n_checked, n_ceiling, n_cascades, biggest_mass;

		function new();
			foreach (lattice[i]) lattice[i] = 0;
			foreach (col_height[i]) col_height[i] = 0;
			errors = 0;
			n_checked = 0;
			n_ceiling = 0;
			n_cascades = 0;
			biggest_mass = 0;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// queue an expected result beat at the back
		function void post_beat(cdce_res_t e);
			expected_beats = {expected_beats, e};
		endfunction

		function void try_join(int nb, byte unsigned sp, ref int tail);
			if (lattice[nb] == sp && !seen[nb]) begin
				seen[nb] = 1;
				fill_queue[tail++] = nb;
			end
		endfunction

		// one generation: flood fill from every shifted cell, drop groups of two or more
		function void remove_groups();
			int head, tail, cur, r, c, gen_cells;
			byte unsigned sp;
			gen_cells = 0;
			foreach (seen[i]) seen[i] = 0;
			foreach (col_lost[i]) col_lost[i] = 0;
			for (int i = 0; i < n_shifted; i++) begin
				cur = shifted[i];
				if (lattice[cur] == 0 || seen[cur]) continue;
				sp = lattice[cur];
				seen[cur] = 1;
				head = 0;
				tail = 1;
				fill_queue[0] = cur;
				while (head < tail) begin
					cur = fill_queue[head++];
					r = cur / NUM_COLS;
					c = cur % NUM_COLS;
					if (r > 0) try_join(cur - NUM_COLS, sp, tail);
					if (r + 1 < NUM_ROWS) try_join(cur + NUM_COLS, sp, tail);
					try_join(r * NUM_COLS + (c + NUM_COLS - 1) % NUM_COLS, sp, tail);
					try_join(r * NUM_COLS + (c + 1) % NUM_COLS, sp, tail);
				end
				if (tail > 1) begin
					for (int k = 0; k < tail; k++) begin
						r = fill_queue[k] / NUM_COLS;
						c = fill_queue[k] % NUM_COLS;
						lattice[fill_queue[k]] = 0;
						if (!col_lost[c]) begin
							col_lost[c] = 1;
							deepest_gap[c] = r;
						end else if (r > deepest_gap[c]) begin
							deepest_gap[c] = r;
						end
						if (!col_hit[c]) begin
							col_hit[c] = 1;
							columns_hit++;
						end
					end
					gen_cells += tail;
					clusters++;
				end
			end
			if (gen_cells > 0) begin
				removed += gen_cells;
				generations++;
			end
		endfunction

		// gravity on the columns that lost cells; cells that fall seed the next round
		function void compact_columns();
			int top, wr, src;
			n_shifted = 0;
			for (int c = 0; c < NUM_COLS; c++) begin
				if (!col_lost[c]) continue;
				top = NUM_ROWS - col_height[c];
				wr = deepest_gap[c];
				for (int r = wr - 1; r >= top && r >= 0; r--) begin
					src = r * NUM_COLS + c;
					if (lattice[src] != 0) begin
						lattice[wr * NUM_COLS + c] = lattice[src];
						lattice[src] = 0;
						shifted[n_shifted++] = wr * NUM_COLS + c;
						wr--;
					end
				end
				col_height[c] = NUM_ROWS - 1 - wr;
			end
		endfunction

		function void note_drop(logic [COLUMN_W-1:0] column_in, logic [SP_W-1:0] sp);
			int col, slope, landing;
			cdce_res_t e;
			col = column_in;
			e = '0;
			if (col_height[col] >= NUM_ROWS) begin
				e.ceiling_hit = 1'b1;
				n_ceiling++;
				post_beat(e);
				return;
			end
			slope = col_height[(col + 1) % NUM_COLS] - col_height[col];
			e.local_slope = slope[SLOPE_W-1:0];
			if (sp == 0) begin
				post_beat(e);
				return;
			end
			landing = (NUM_ROWS - 1 - col_height[col]) * NUM_COLS + col;
			lattice[landing] = sp;
			col_height[col]++;
			removed = 0;
			clusters = 0;
			generations = 0;
			columns_hit = 0;
			foreach (col_hit[i]) col_hit[i] = 0;
			shifted[0] = landing;
			n_shifted = 1;
			do begin
				remove_groups();
				compact_columns();
			end while (n_shifted != 0);
			if (removed > 0) n_cascades++;
			if (removed > biggest_mass) biggest_mass = removed;
			e.cascade_mass = MASS_W'(removed);
			e.cluster_count = CLU_W'(clusters);
			e.generation_count = GEN_W'(generations);
			e.column_extent = EXT_W'(columns_hit);
			post_beat(e);
		endfunction

		function void check_result(cdce_res_t got);
			cdce_res_t e;
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %p", $time, got);
				errors++;
				return;
			end
			e = expected_beats.pop_front();
			n_checked++;
			if (got.ceiling_hit !== e.ceiling_hit) begin
				$display("%0t: ceiling_hit expected %0d actual %0d", $time,
					e.ceiling_hit, got.ceiling_hit);
				errors++;
			end
			if (got.local_slope !== e.local_slope) begin
				$display("%0t: local_slope expected %0d actual %0d", $time,
					$signed(e.local_slope), $signed(got.local_slope));
				errors++;
			end
			if (got.cascade_mass !== e.cascade_mass) begin
				$display("%0t: cascade_mass expected %0d actual %0d", $time,
					e.cascade_mass, got.cascade_mass);
				errors++;
			end
			if (got.cluster_count !== e.cluster_count) begin
				$display("%0t: cluster_count expected %0d actual %0d", $time,
					e.cluster_count, got.cluster_count);
				errors++;
			end
			if (got.generation_count !== e.generation_count) begin
				$display("%0t: generation_count expected %0d actual %0d", $time,
					e.generation_count, got.generation_count);
				errors++;
			end
			if (got.column_extent !== e.column_extent) begin
				$display("%0t: column_extent expected %0d actual %0d", $time,
					e.column_extent, got.column_extent);
				errors++;
			end
		endfunction
	endclass

	// generous: the clearing pass, slow cascades and all stalls several times over
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int LONG_HOLD   = 3000;
	localparam int HOLD_AT     = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [COLUMN_W-1:0]    column;
	logic [SP_W-1:0]        species;
	logic                   out_valid;
	logic                   out_ready;
	logic                   ceiling_hit;
	logic signed [SLOPE_W-1:0] local_slope;
	logic [MASS_W-1:0]      cascade_mass;
	logic [CLU_W-1:0]       cluster_count;
	logic [GEN_W-1:0]       generation_count;
	logic [EXT_W-1:0]       column_extent;

	drop_scoreboard sb;
	int  cycles;
	int  n_sent;
	bit  hold_done;
	bit  burst_open;
	int  burst_left;

	column_drop_cascade_eliminator DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.column           (column),
		.species          (species),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.ceiling_hit      (ceiling_hit),
		.local_slope      (local_slope),
		.cascade_mass     (cascade_mass),
		.cluster_count    (cluster_count),
		.generation_count (generation_count),
		.column_extent    (column_extent)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// predictor fed on every accepted input beat, checker on every result beat
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_drop(column, species);
		if (arst_n && out_valid && out_ready)
			sb.check_result({ceiling_hit, local_slope, cascade_mass, cluster_count,
				generation_count, column_extent});
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				sb.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: runs of full acceptance, runs of random stalls, and one long
	// hold-off once enough beats have gone in so the block backs up
	initial begin : receiver
		int run, mode;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && n_sent >= HOLD_AT) begin
				hold_done = 1;
				out_ready <= 0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			run = $urandom_range(1, 60);
			mode = $urandom_range(0, 2);
			repeat (run) begin
				case (mode)
					0: out_ready <= 1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// offers one beat and holds it until taken; a burst keeps valid high
	// straight into the next beat, otherwise valid goes low between the two beats
	task automatic send_drop(input logic [COLUMN_W-1:0] col, input logic [SP_W-1:0] sp);
		if (!burst_open) begin
			if (burst_left == 0) begin
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end else begin
				@(posedge clk);
			end
		end
		in_valid <= 1;
		column <= col;
		species <= sp;
		do @(posedge clk); while (!in_ready);
		n_sent++;
		burst_left--;
		burst_open = (burst_left > 0) && ($urandom_range(0, 9) != 0);
		if (!burst_open) in_valid <= 0;
	endtask

	// first let the scoreboard take in the last accepted beat, then wait until no result is pending
	task automatic drain();
		if (burst_open) begin
			in_valid <= 0;
			burst_open = 0;
		end
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// mostly a few species so groups form and cascades run; sometimes any species
	task automatic random_drop();
		int pick;
		logic [SP_W-1:0] sp;
		pick = $urandom_range(0, 99);
		if (pick < 80) sp = SP_W'($urandom_range(1, 4));
		else if (pick < 95) sp = SP_W'($urandom_range(1, 255));
		else sp = '0;
		send_drop(COLUMN_W'($urandom_range(0, NUM_COLS - 1)), sp);
	endtask

	// a column stacked with two alternating species that never group, until it
	// is full and further drops bounce off the ceiling
	task automatic tower(input int col);
		for (int k = 0; k < NUM_ROWS + 4; k++)
			send_drop(COLUMN_W'(col), (k % 2) ? 8'd250 : 8'd251);
	endtask

	initial begin : stimulus
		sb = new();
		cycles = 0;
		n_sent = 0;
		hold_done = 0;
		burst_open = 0;
		burst_left = 0;
		arst_n = 0;
		in_valid = 0;
		column = '0;
		species = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// directed: field extremes, species zero, wrap of the slope neighbour, diagonal
		// (not adjacent) cells of one species across the wrap, vertical and horizontal pairs
		send_drop(6'd0, 8'd255);
		send_drop(6'd63, 8'd1);
		send_drop(6'd63, 8'd0);
		send_drop(6'd0, 8'd0);
		send_drop(6'd0, 8'd1);
		send_drop(6'd63, 8'd255);
		send_drop(6'd10, 8'd7);
		send_drop(6'd10, 8'd7);
		send_drop(6'd20, 8'd2);
		send_drop(6'd20, 8'd3);
		send_drop(6'd20, 8'd3);
		send_drop(6'd21, 8'd2);
		send_drop(6'd30, 8'd5);
		send_drop(6'd30, 8'd6);
		send_drop(6'd31, 8'd6);
		send_drop(6'd32, 8'd5);
		send_drop(6'd31, 8'd5);
		send_drop(6'd42, 8'h80);
		send_drop(6'd21, 8'h7f);
		send_drop(6'd63, 8'd0);
		// sender stands still until every result is back
		drain();

		tower(45);
		for (int i = 0; i < 1300; i++) begin
			random_drop();
			if (i == 500) tower(5);
			if (i == 900) begin
				drain();
				tower(33);
			end
		end
		drain();
		repeat (200) @(posedge clk);

		$display("%0d drops, %0d results checked: %0d ceiling hits,", n_sent,
			sb.n_checked, sb.n_ceiling);
		$display("%0d cascades, largest %0d cells", sb.n_cascades, sb.biggest_mass);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
src/cdce_pkg.sv
src/cdce_ctrl.sv
src/cdce_dp.sv
src/column_drop_cascade_eliminator.sv
tb/column_drop_cascade_eliminator_test.sv
